// ===== hdl/h264psl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 parameter set locator package
// Shared item types, scan phase codes, NAL unit types and status codes.
// ----------------------------------------------------------------------------
package h264psl_pkg;

    // Annex B start code as seen in a four-byte window.
    localparam logic [31:0] SYNC_WORD = 32'h0000_0001;
    localparam logic [7:0]  TYPE_MASK = 8'd31;

    localparam logic [4:0] NAL_SEI = 5'd6;
    localparam logic [4:0] NAL_SPS = 5'd7;
    localparam logic [4:0] NAL_PPS = 5'd8;

    localparam logic [7:0] MAX_SETS_RESET = 8'd32;

    localparam int OUT_DEPTH_DEFAULT = 4;

    // Register map (word index within the configuration port).
    localparam logic ADDR_MAX_SETS = 1'b0;

    typedef enum logic [1:0] {
        STATUS_SUCCESS  = 2'd0,
        STATUS_MISSING  = 2'd1,
        STATUS_TOO_MANY = 2'd2,
        STATUS_INVALID  = 2'd3
    } scan_status_t;

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [3:0] {
        PH_SEARCH = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_INSET  = 4'b0100,
        PH_DONE   = 4'b1000
    } scan_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_first;
        logic       stream_last;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic        set_type;
        logic [7:0]  set_index;
        logic [31:0] set_start;
        logic [31:0] set_length;
        logic [1:0]  scan_status;
        logic        run_last;
    } out_item_t;

endpackage : h264psl_pkg
`default_nettype wire

// ===== hdl/h264_parameter_set_locator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// H.264 parameter set locator
// Scans an Annex B byte stream and reports where each SPS and PPS lies.
// ----------------------------------------------------------------------------
// Usage
//   Stream bytes enter on the s_ channel, one item per byte, with flags that
//   mark the first and the last byte of a stream. Each SPS or PPS produces a
//   record item on the m_ channel once the next start code closes it, and the
//   scan ends with one status item. The max_sets limit is written through
//   the APB port at byte address 0 while the block is idle.
// Latency and throughput
//   A byte is decoded in the cycle it is accepted against the scan state
//   registers; its results enter the output queue at that edge and are
//   offered on m_ from the next cycle. One byte is taken every cycle while
//   the output queue has room. A byte yields at most two result items, so
//   the rate is set by the output queue, which drains one item a cycle and
//   accepts a byte whenever two slots remain free.
// Reset and stalls
//   aresetn clears the scan state, empties the queue and restores max_sets
//   to 32. When the receiver stalls, queued items hold and input keeps
//   flowing until the queue has fewer than two free slots.
// ----------------------------------------------------------------------------
module h264_parameter_set_locator_top
    import h264psl_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,

    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(OUT_DEPTH - 2);

    // ------------------------------------------------------------------
    // Configuration port. Writes land on the access phase; reads return
    // the register, and addresses past the map read as zero.
    // ------------------------------------------------------------------
    logic [7:0] max_sets_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_sets_reg <= MAX_SETS_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_MAX_SETS)) begin
            max_sets_reg <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == ADDR_MAX_SETS) begin
            prdata = {24'd0, max_sets_reg};
        end
    end

    // ------------------------------------------------------------------
    // Scan state.
    // ------------------------------------------------------------------
    logic [23:0]  window_reg,    window_next;
    logic [31:0]  offset_reg,    offset_next;
    scan_phase_t  phase_reg,     phase_next;
    logic         open_type_reg, open_type_next;
    logic [31:0]  open_start_reg, open_start_next;
    logic [7:0]   sps_count_reg, sps_count_next;
    logic [7:0]   pps_count_reg, pps_count_next;

    logic in_fire;
    assign in_fire = s_valid && s_ready;

    // A first byte sees the cleared state rather than the registers.
    logic [23:0] cur_window;
    logic [31:0] cur_offset;
    scan_phase_t cur_phase;
    logic        cur_open_type;
    logic [31:0] cur_open_start;
    logic [7:0]  cur_sps, cur_pps;

    logic [31:0] win;
    logic        sc_hit;
    logic [4:0]  nal_type;
    logic [7:0]  cur_count;
    logic [8:0]  count_inc;

    logic         rec_valid;
    logic         stat_valid;
    scan_status_t stat_code;

    always_comb begin
        if (s_data.stream_first) begin
            cur_window     = 24'd0;
            cur_offset     = 32'd0;
            cur_phase      = PH_SEARCH;
            cur_open_type  = 1'b0;
            cur_open_start = 32'd0;
            cur_sps        = 8'd0;
            cur_pps        = 8'd0;
        end else begin
            cur_window     = window_reg;
            cur_offset     = offset_reg;
            cur_phase      = phase_reg;
            cur_open_type  = open_type_reg;
            cur_open_start = open_start_reg;
            cur_sps        = sps_count_reg;
            cur_pps        = pps_count_reg;
        end

        win        = {cur_window, s_data.data_byte};
        sc_hit     = (win == SYNC_WORD) && (cur_offset >= 32'd3);
        nal_type   = s_data.data_byte[4:0] & TYPE_MASK[4:0];
        cur_count  = cur_open_type ? cur_pps : cur_sps;
        count_inc  = {1'b0, cur_count} + 9'd1;

        window_next     = win[23:0];
        offset_next     = (cur_offset == 32'hFFFF_FFFF) ? cur_offset : cur_offset + 32'd1;
        phase_next      = cur_phase;
        open_type_next  = cur_open_type;
        open_start_next = cur_open_start;
        sps_count_next  = cur_sps;
        pps_count_next  = cur_pps;
        rec_valid       = 1'b0;
        stat_valid      = 1'b0;
        stat_code       = STATUS_SUCCESS;

        unique case (cur_phase)
            PH_DONE: begin
                // Ignored bytes leave the state alone.
                window_next = cur_window;
                offset_next = cur_offset;
            end
            PH_HEADER: begin
                if (nal_type == NAL_SPS || nal_type == NAL_PPS) begin
                    open_type_next  = (nal_type == NAL_PPS);
                    open_start_next = cur_offset - 32'd4;
                    phase_next      = PH_INSET;
                end else if (nal_type == NAL_SEI) begin
                    phase_next = PH_SEARCH;
                end else begin
                    stat_valid = 1'b1;
                    stat_code  = (cur_sps != 8'd0 && cur_pps != 8'd0) ?
                                 STATUS_SUCCESS : STATUS_MISSING;
                    phase_next = PH_DONE;
                end
            end
            PH_INSET: begin
                if (sc_hit) begin
                    rec_valid = 1'b1;
                    if (count_inc > {1'b0, max_sets_reg}) begin
                        stat_valid = 1'b1;
                        stat_code  = STATUS_TOO_MANY;
                        phase_next = PH_DONE;
                    end else begin
                        if (cur_open_type) begin
                            pps_count_next = count_inc[7:0];
                        end else begin
                            sps_count_next = count_inc[7:0];
                        end
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_SEARCH: begin
                if (sc_hit) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                phase_next = PH_SEARCH;
            end
        endcase

        // The last byte of a stream that has not finished is an invalid stream.
        if (s_data.stream_last && cur_phase != PH_DONE && phase_next != PH_DONE) begin
            stat_valid = 1'b1;
            stat_code  = STATUS_INVALID;
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= 24'd0;
            offset_reg     <= 32'd0;
            phase_reg      <= PH_SEARCH;
            open_type_reg  <= 1'b0;
            open_start_reg <= 32'd0;
            sps_count_reg  <= 8'd0;
            pps_count_reg  <= 8'd0;
        end else if (in_fire) begin
            window_reg     <= window_next;
            offset_reg     <= offset_next;
            phase_reg      <= phase_next;
            open_type_reg  <= open_type_next;
            open_start_reg <= open_start_next;
            sps_count_reg  <= sps_count_next;
            pps_count_reg  <= pps_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result items. A record, when present, always precedes the status.
    // ------------------------------------------------------------------
    out_item_t rec_item, stat_item, item0, item1;
    logic [1:0] push_n;

    always_comb begin
        rec_item             = '0;
        rec_item.result_kind = KIND_RECORD;
        rec_item.set_type    = cur_open_type;
        rec_item.set_index   = cur_count;
        rec_item.set_start   = cur_open_start;
        rec_item.set_length  = (cur_offset - 32'd3) - cur_open_start;
        rec_item.run_last    = !stat_valid;

        stat_item             = '0;
        stat_item.result_kind = KIND_STATUS;
        stat_item.scan_status = stat_code;
        stat_item.run_last    = 1'b1;

        item0 = rec_valid ? rec_item : stat_item;
        item1 = stat_item;

        if (!in_fire) begin
            push_n = 2'd0;
        end else begin
            push_n = {1'b0, rec_valid} + {1'b0, stat_valid};
        end
    end

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    out_item_t        queue_reg [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_fire;

    assign m_valid  = (count_reg != '0);
    assign m_data   = queue_reg[rd_ptr_reg];
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (count_reg <= CNT_ROOM);

    always_comb begin
        wr_ptr_plus1 = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = (wr_ptr_plus1 == PTR_LAST) ? '0 : wr_ptr_plus1 + PTR_W'(1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        if (out_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end else begin
            rd_ptr_next = rd_ptr_reg;
        end
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(out_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= item0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_plus1] <= item1;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(OUT_DEPTH))
        else $error("output queue overfilled");

    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_data.stream_first && phase_reg == PH_DONE) |->
        (push_n == 2'd0) ##1 (phase_reg == PH_DONE))
        else $error("ignored byte changed the scan");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n == 2'd2) |-> (item0.result_kind == KIND_RECORD &&
                              item1.result_kind == KIND_STATUS && !item0.run_last))
        else $error("two results not ordered record then status");

    a_status_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && stat_valid) |=> (phase_reg == PH_DONE))
        else $error("status given but scan not finished");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != 2'd0 && !out_fire) |=> (count_reg == $past(count_reg) + CNT_W'($past(push_n))))
        else $error("queue count out of step with pushes");

endmodule : h264_parameter_set_locator_top
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the H.264 parameter set locator
// Feeds Annex B byte streams into the block and checks every record and
// status item against a predictor that tracks the scan byte by byte. Both
// the input and the result side idle at random, the max_sets limit is moved
// through several values over the APB port, and one phase holds the
// receiver off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module testbench;
    import h264psl_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    h264_parameter_set_locator_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: a private copy of the scan registers and the limit.
    logic [23:0]  look_back;
    logic [31:0]  byte_pos;
    scan_phase_t  phase;
    logic         open_is_pps;
    logic [31:0]  open_start;
    logic [7:0]   sps_seen;
    logic [7:0]   pps_seen;
    logic [7:0]   max_sets_now;

    // Results that the scan is due to produce, oldest first.
    out_item_t    records_due[$];
    logic [7:0]   stream_q[$];

    int bad_results   = 0;
    int bytes_sent    = 0;
    int rx_hold_cycles = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A generous bound on the whole run; a correct run ends far earlier.
    initial begin
        #3_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_scan();
        look_back   = '0;
        byte_pos    = '0;
        phase       = PH_SEARCH;
        open_is_pps = 1'b0;
        open_start  = '0;
        sps_seen    = '0;
        pps_seen    = '0;
    endfunction

    function automatic out_item_t status_item(input scan_status_t st);
        out_item_t r;
        r = '0;
        r.result_kind = KIND_STATUS;
        r.scan_status = st;
        return r;
    endfunction

    // Advances the scan by one accepted byte and queues the results it
    // causes. Returns 0 when the byte is ignored because a status was given.
    function automatic bit scan_byte(input in_item_t it);
        out_item_t   due [2];
        int          n;
        logic [31:0] pos;
        logic [31:0] window;
        logic [4:0]  nal;
        logic        hit;
        int          cnt;
        n = 0;
        if (it.stream_first)
            clear_scan();
        if (phase == PH_DONE)
            return 1'b0;

        pos    = byte_pos;
        window = {look_back, it.data_byte};
        // A start code only counts once four bytes of this stream are in.
        hit       = (window == SYNC_WORD) && (pos >= 32'd3);
        look_back = window[23:0];
        if (byte_pos != 32'hFFFF_FFFF)
            byte_pos++;

        if (phase == PH_HEADER) begin
            nal = 5'(it.data_byte & TYPE_MASK);
            if (nal == NAL_SPS || nal == NAL_PPS) begin
                open_is_pps = (nal == NAL_PPS);
                open_start  = pos - 32'd4;
                phase       = PH_INSET;
            end else if (nal == NAL_SEI) begin
                phase = PH_SEARCH;
            end else begin
                due[n++] = status_item((sps_seen != 0 && pps_seen != 0) ?
                                       STATUS_SUCCESS : STATUS_MISSING);
                phase = PH_DONE;
            end
        end else if (hit) begin
            if (phase == PH_INSET) begin
                // The open set is closed and counted here.
                cnt = open_is_pps ? int'(pps_seen) : int'(sps_seen);
                due[n] = '0;
                due[n].result_kind = KIND_RECORD;
                due[n].set_type    = open_is_pps;
                due[n].set_index   = 8'(cnt);
                due[n].set_start   = open_start;
                due[n].set_length  = (pos - 32'd3) - open_start;
                n++;
                if (cnt + 1 > int'(max_sets_now)) begin
                    due[n++] = status_item(STATUS_TOO_MANY);
                    phase = PH_DONE;
                end else begin
                    if (open_is_pps)
                        pps_seen = 8'(cnt + 1);
                    else
                        sps_seen = 8'(cnt + 1);
                    phase = PH_HEADER;
                end
            end else begin
                phase = PH_HEADER;
            end
        end

        // The end of the buffer without a status drops any open set.
        if (it.stream_last && phase != PH_DONE) begin
            due[n++] = status_item(STATUS_INVALID);
            phase = PH_DONE;
        end

        for (int i = 0; i < n; i++) begin
            due[i].run_last = (i == n - 1);
            records_due.push_back(due[i]);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, a long hold-off on request, and the checker
    // ------------------------------------------------------------------------
    initial begin : receiver
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            gap = rx_idle_on ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid && rx_hold_cycles == 0);
            @(negedge aclk);
        end
    end

    function automatic string describe(input out_item_t r);
        return $sformatf("kind=%0d type=%0d index=%0d start=%0d length=%0d status=%0d last=%0d",
                         r.result_kind, r.set_type, r.set_index, r.set_start,
                         r.set_length, r.scan_status, r.run_last);
    endfunction

    task automatic report_bad(input string why, input out_item_t want, input out_item_t got);
        bad_results++;
        if (bad_results <= 10)
            $display("%s: expected %s, got %s", why, describe(want), describe(got));
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (records_due.size() == 0) begin
                report_bad("result with nothing expected", '0, m_data);
            end else begin
                want = records_due.pop_front();
                if (m_data.result_kind !== want.result_kind ||
                    m_data.set_type    !== want.set_type    ||
                    m_data.set_index   !== want.set_index   ||
                    m_data.set_start   !== want.set_start   ||
                    m_data.set_length  !== want.set_length  ||
                    m_data.scan_status !== want.scan_status ||
                    m_data.run_last    !== want.run_last)
                    report_bad("result mismatch", want, m_data);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side and configuration port
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic first_f, input logic last_f);
        in_item_t it;
        int       gap;
        it.data_byte    = b;
        it.stream_first = first_f;
        it.stream_last  = last_f;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // The item is taken; its results cannot leave before the next edge.
        @(negedge aclk);
        void'(scan_byte(it));
        bytes_sent++;
    endtask

    task automatic send_stream(input bit with_first, input bit with_last);
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], with_first && i == 0,
                      with_last && i == stream_q.size() - 1);
    endtask

    task automatic add_sync_word();
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h01);
    endtask

    // Stops offering items until every expected result has come, then lets
    // the block settle, since some bytes cause no result.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (records_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic config_write(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ADDR_MAX_SETS, 2'b00};
        // Only the low byte is held; the upper bits are noise.
        pwdata  <= {24'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        max_sets_now = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One hand-built stream under the reset limit: a start code pattern in the
    // first bytes that must not count, an SPS with set priority bits and a PPS
    // with set forbidden and priority bits, an SEI that is skipped, then a slice
    // that ends the scan with success. A final byte marked last arrives after
    // the status and is ignored.
    task automatic test_directed_stream();
        logic [7:0] bytes [0:22] = '{
            8'h00, 8'h00, 8'h01,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF,
            8'h00, 8'h00, 8'h00, 8'h01, 8'hE8,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h06,
            8'h00, 8'h00, 8'h00, 8'h01};
        stream_q.delete();
        foreach (bytes[i])
            stream_q.push_back(bytes[i]);
        stream_q.push_back(8'h65);
        send_stream(1'b1, 1'b0);
        send_byte(8'h80, 1'b0, 1'b1);
    endtask

    // With a limit of one, the second SPS to close is one too many: its record
    // comes first, then the status. A lone byte marked both first and last
    // then restarts the scan and ends it as an invalid stream.
    task automatic test_set_limit();
        wait_drained();
        config_write(8'd1);
        stream_q.delete();
        add_sync_word();
        stream_q.push_back(8'h67);
        add_sync_word();
        stream_q.push_back(8'h67);
        add_sync_word();
        send_stream(1'b1, 1'b0);
        send_byte(8'h5A, 1'b1, 1'b1);
    endtask

    // Tightly packed sets produce a record every five bytes. The receiver
    // holds off for a long stretch while the sender keeps offering bytes, so
    // the result queue fills and the input is stalled.
    task automatic test_backpressure();
        wait_drained();
        config_write(8'd255);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        stream_q.delete();
        for (int u = 0; u < 14; u++) begin
            add_sync_word();
            stream_q.push_back(u[0] ? 8'h68 : 8'h27);
        end
        add_sync_word();
        stream_q.push_back(8'h41);
        rx_hold_cycles = 300;
        send_stream(1'b1, 1'b0);
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    // Builds one well-formed stream with random content: leading junk, a few
    // units (mostly SPS and PPS, some SEI, some other types), and an ending
    // that either names a type other than SPS, PPS or SEI, stops inside a set or cuts a start code.
    task automatic build_stream();
        int         units;
        int         pick;
        int         nal;
        stream_q.delete();
        repeat ($urandom_range(0, 3))
            stream_q.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom));
        units = $urandom_range(0, 5);
        for (int u = 0; u < units; u++) begin
            add_sync_word();
            pick = $urandom_range(0, 9);
            nal  = (pick < 4) ? NAL_SPS : (pick < 8) ? NAL_PPS :
                   (pick == 8) ? NAL_SEI : $urandom_range(0, 31);
            stream_q.push_back({3'($urandom), 5'(nal)});
            repeat ($urandom_range(0, 6))
                stream_q.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            add_sync_word();
            nal = $urandom_range(0, 28);
            if (nal >= NAL_SEI)
                nal += 3;
            stream_q.push_back({3'($urandom), 5'(nal)});
            repeat ($urandom_range(0, 2))
                stream_q.push_back(8'($urandom));
        end else if (pick == 9) begin
            repeat (3) stream_q.push_back(8'h00);
        end
    endtask

    // Random streams over five limit settings, the extremes among them. Most
    // streams are well formed; some lack their first or last mark, and a few
    // bursts are pure noise with random flags.
    task automatic test_random_streams(input int target);
        logic [7:0] setting;
        int         phase_end;
        for (int p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                0: begin
                    setting = 8'd1;
                end
                1: begin
                    setting = 8'd255;
                end
                2: begin
                    setting = 8'($urandom_range(2, 4));
                end
                3: begin
                    setting = 8'($urandom_range(5, 254));
                end
                default: begin
                    setting = 8'd2;
                end
            endcase
            config_write(setting);
            phase_end = bytes_sent + target / 5;
            while (bytes_sent < phase_end) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(6, 20))
                        send_byte(8'($urandom), $urandom_range(0, 7) == 0,
                                  $urandom_range(0, 7) == 0);
                end else begin
                    build_stream();
                    send_stream($urandom_range(0, 9) != 0, $urandom_range(0, 1) == 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        clear_scan();
        max_sets_now = MAX_SETS_RESET;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_stream();
        test_set_limit();
        test_backpressure();
        test_random_streams(300);

        s_valid <= 1'b0;
        tx_idle_on = 1'b0;
        for (int k = 0; k < 20000 && records_due.size() != 0; k++)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (records_due.size() != 0) begin
            $display("testbench: %0d expected results never arrived", records_due.size());
            bad_results++;
        end
        if (bad_results == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== h264_parameter_set_locator_top.f =====
hdl/h264psl_pkg.sv
hdl/h264_parameter_set_locator_top.sv
test/testbench.sv
